// ===== rtl/kfca_pkg.sv =====
package kfca_pkg;

	localparam int W     = 32;
	localparam int F     = 16;
	localparam int DTW   = 20;
	localparam int VW    = 31;
	localparam int NB    = W + F;
	localparam int OUT_W = 6 * W + 2 * VW + 2;

	localparam int PROG_LEN = 80;
	localparam int PC_W     = $clog2(PROG_LEN);

	// configuration register indexes
	localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE    = 2'd2;
	localparam logic [1:0] REG_INIT_VAR      = 2'd3;

	localparam logic [DTW-1:0] RST_SAMPLE_PERIOD = DTW'(6554);
	localparam logic [VW-1:0]  RST_PROCESS_NOISE = VW'(65536);
	localparam logic [VW-1:0]  RST_MEAS_NOISE    = VW'(655);
	localparam logic [VW-1:0]  RST_INIT_VAR      = VW'(6553600);

	// operand codes: bit 5 clear selects a per-axis register file entry
	localparam logic [5:0] L_X0  = 6'd0;
	localparam logic [5:0] L_P00 = 6'd3;
	localparam logic [5:0] L_P11 = 6'd7;
	localparam logic [5:0] L_P22 = 6'd11;
	localparam logic [5:0] L_K0  = 6'd12;
	localparam logic [5:0] L_R0  = 6'd15;
	localparam logic [5:0] L_S   = 6'd18;
	localparam logic [5:0] L_E   = 6'd19;
	localparam logic [5:0] L_T1  = 6'd20;
	localparam logic [5:0] L_T2  = 6'd21;
	localparam logic [5:0] L_H   = 6'd22;
	localparam logic [5:0] C_DT  = 6'd32;
	localparam logic [5:0] C_Q   = 6'd33;
	localparam logic [5:0] C_R   = 6'd34;
	localparam logic [5:0] C_Z   = 6'd35;

	localparam logic [3:0] LOC_FIRST_COV = 4'd3;
	localparam logic [3:0] LOC_LAST      = 4'd11;

	typedef enum logic [2:0] {
		OP_MUL, OP_MULH, OP_ADD, OP_SUB, OP_DIV, OP_CPY, OP_BRP, OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] dst;
		logic [5:0] a;
		logic [5:0] b;
	} instr_t;

	typedef instr_t [PROG_LEN-1:0] prog_t;

	typedef enum logic [2:0] {
		ST_INIT, ST_LOAD, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WB, ST_FIN
	} state_t;

	typedef struct packed {
		logic           capture;
		logic           axis;
		instr_t         instr;
		logic           mul_en;
		logic           div_start;
		logic           wb;
		logic           fill;
		logic [3:0]     fill_loc;
		logic           out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic nonpos;
	} sts_t;

	typedef struct packed {
		logic [DTW-1:0] dt;
		logic [VW-1:0]  q;
		logic [VW-1:0]  r;
		logic [VW-1:0]  iv;
	} cfg_t;

	function automatic instr_t mk(op_t o, logic [5:0] d, logic [5:0] a, logic [5:0] b);
		instr_t t;
		t.op  = o;
		t.dst = d;
		t.a   = a;
		t.b   = b;
		return t;
	endfunction

	// one axis: predict, innovation check, gains, update
	function automatic prog_t build_prog();
		prog_t p;
		int n;
		int k;
		int i;
		int j;
		int a0;
		int a1;
		int a2;
		p = '0;
		n = 0;
		p[n] = mk(OP_MULH, L_H, C_DT, C_DT);
		n = n + 1;
		for (k = 0; k < 7; k++) begin
			if (k == 0) begin
				a0 = 0; a1 = 1; a2 = 2;
			end else if (k < 4) begin
				a0 = 3 + k - 1; a1 = 6 + k - 1; a2 = 9 + k - 1;
			end else begin
				a0 = 3 + 3 * (k - 4); a1 = a0 + 1; a2 = a0 + 2;
			end
			p[n]     = mk(OP_MUL, L_T1, C_DT, 6'(a1));
			p[n + 1] = mk(OP_MUL, L_T2, L_H, 6'(a2));
			p[n + 2] = mk(OP_ADD, 6'(a0), 6'(a0), L_T1);
			p[n + 3] = mk(OP_ADD, 6'(a0), 6'(a0), L_T2);
			p[n + 4] = mk(OP_MUL, L_T1, C_DT, 6'(a2));
			p[n + 5] = mk(OP_ADD, 6'(a1), 6'(a1), L_T1);
			n = n + 6;
		end
		for (i = 0; i < 3; i++) begin
			p[n] = mk(OP_ADD, 6'(3 + 4 * i), 6'(3 + 4 * i), C_Q);
			n = n + 1;
		end
		p[n]     = mk(OP_ADD, L_S, L_P00, C_R);
		p[n + 1] = mk(OP_BRP, L_X0, L_X0, L_X0);
		p[n + 2] = mk(OP_SUB, L_E, C_Z, L_X0);
		n = n + 3;
		for (i = 0; i < 3; i++) begin
			p[n] = mk(OP_DIV, 6'(12 + i), 6'(3 + 3 * i), L_S);
			n = n + 1;
		end
		for (j = 0; j < 3; j++) begin
			p[n] = mk(OP_CPY, 6'(15 + j), 6'(3 + j), 6'(3 + j));
			n = n + 1;
		end
		for (i = 0; i < 3; i++) begin
			p[n]     = mk(OP_MUL, L_T1, 6'(12 + i), L_E);
			p[n + 1] = mk(OP_ADD, 6'(i), 6'(i), L_T1);
			n = n + 2;
			for (j = 0; j < 3; j++) begin
				p[n]     = mk(OP_MUL, L_T1, 6'(12 + i), 6'(15 + j));
				p[n + 1] = mk(OP_SUB, 6'(3 + 3 * i + j), 6'(3 + 3 * i + j), L_T1);
				n = n + 2;
			end
		end
		p[n] = mk(OP_END, L_X0, L_X0, L_X0);
		return p;
	endfunction

	localparam prog_t PROG = build_prog();

	// magnitude and sign to a saturated word; top bit of the result is the clip flag
	function automatic logic [W:0] pack_word(logic neg, logic [2*W:0] m);
		logic [2*W:0] lim;
		logic [2*W:0] v;
		logic         clip;
		lim  = neg ? ((2*W+1)'(1) << (W - 1)) : (((2*W+1)'(1) << (W - 1)) - (2*W+1)'(1));
		clip = m > lim;
		v    = clip ? lim : m;
		return {clip, neg ? W'((2*W+1)'(0) - v) : W'(v)};
	endfunction

endpackage

// ===== rtl/kfca_div.sv =====
module kfca_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  neg,
	input  logic [kfca_pkg::W-1:0] num,
	input  logic [kfca_pkg::W-1:0] den,
	output logic                  done,
	output logic [kfca_pkg::W-1:0] res,
	output logic                  clip
);
	import kfca_pkg::*;

	localparam int CNT_W = $clog2(NB);

	logic             busy_q;
	logic             fin_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NB-1:0]    sh_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic             neg_q;
	logic [W-1:0]     res_q;
	logic             clip_q;

	logic [W-1:0]     t;
	logic             ge;
	logic             up;
	logic [2*W:0]     qr;
	logic [W:0]       pk;

	// restoring step, one quotient bit per cycle
	assign t  = {rem_q[W-2:0], sh_q[NB-1]};
	assign ge = t >= den_q;
	// round half away from zero on the magnitude
	assign up = rem_q >= (den_q - rem_q);
	assign qr = (2*W+1)'(sh_q) + (2*W+1)'(up);
	assign pk = pack_word(neg_q, qr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NB - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= {num, {F{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? (t - den_q) : t;
			sh_q  <= {sh_q[NB-2:0], ge};
		end
		if (fin_q) begin
			res_q  <= pk[W-1:0];
			clip_q <= pk[W];
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign clip = clip_q;

endmodule

// ===== rtl/kfca_dp.sv =====
module kfca_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kfca_pkg::cmd_t             cmd,
	input  kfca_pkg::cfg_t             cfg,
	input  logic [2*kfca_pkg::W-1:0]   in_data,
	output kfca_pkg::sts_t             sts,
	output logic [kfca_pkg::OUT_W-1:0] out_data
);
	import kfca_pkg::*;

	localparam int ADDR_W = 6;

	logic [W-1:0]  rf [0:2**ADDR_W-1];
	logic [W-1:0]  rda_q;
	logic [W-1:0]  rdb_q;
	logic [W-1:0]  zx_q;
	logic [W-1:0]  zy_q;
	logic [2*W-1:0] prod_q;
	logic          pneg_q;
	logic          clip_q;
	logic          nonpos_q;
	logic [W-1:0]  est_sh_q [0:5];
	logic [W-1:0]  var_sh_q [0:1];
	logic [OUT_W-1:0] out_q;

	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic [ADDR_W-1:0] waddr;
	logic [W-1:0]  opa;
	logic [W-1:0]  opb;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [2*W:0]  rnd_f;
	logic [2*W:0]  rnd_h;
	logic [2*W:0]  mres;
	logic [W:0]    mpk;
	logic [W:0]    sum;
	logic          ovf;
	logic [W-1:0]  sat_res;
	logic [W-1:0]  res;
	logic          res_clip;
	logic          we;
	logic [W-1:0]  wdata;
	logic [W-1:0]  fill_val;
	logic [4:0]    wloc;
	logic [2:0]    sh_idx;
	logic          div_done;
	logic [W-1:0]  div_res;
	logic          div_clip;
	logic          negx;
	logic          negy;
	logic [VW-1:0] vx;
	logic [VW-1:0] vy;

	function automatic logic [W-1:0] opnd(logic [5:0] code, logic [W-1:0] rd,
			cfg_t c, logic ax, logic [W-1:0] zx, logic [W-1:0] zy);
		logic [W-1:0] v;
		if (!code[5]) begin
			v = rd;
		end else begin
			case (code)
				C_DT:    v = {{(W-DTW){1'b0}}, c.dt};
				C_Q:     v = {{(W-VW){1'b0}}, c.q};
				C_R:     v = {{(W-VW){1'b0}}, c.r};
				C_Z:     v = ax ? zy : zx;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	assign addr_a = {cmd.axis, cmd.instr.a[4:0]};
	assign addr_b = {cmd.axis, cmd.instr.b[4:0]};
	assign opa    = opnd(cmd.instr.a, rda_q, cfg, cmd.axis, zx_q, zy_q);
	assign opb    = opnd(cmd.instr.b, rdb_q, cfg, cmd.axis, zx_q, zy_q);
	assign mag_a  = opa[W-1] ? (W'(0) - opa) : opa;
	assign mag_b  = opb[W-1] ? (W'(0) - opb) : opb;

	// product rounding: shift by F, or F+1 for dt*dt/2
	assign rnd_f = {1'b0, prod_q} + ((2*W+1)'(1) << (F - 1));
	assign rnd_h = {1'b0, prod_q} + ((2*W+1)'(1) << F);
	assign mres  = (cmd.instr.op == OP_MULH) ? (rnd_h >> (F + 1)) : (rnd_f >> F);
	assign mpk   = pack_word(pneg_q, mres);

	// saturating add and subtract
	assign sum = (cmd.instr.op == OP_SUB) ? ({opa[W-1], opa} - {opb[W-1], opb})
	                                      : ({opa[W-1], opa} + {opb[W-1], opb});
	assign ovf = sum[W] ^ sum[W-1];
	assign sat_res = ovf ? (sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
	                     : sum[W-1:0];

	always_comb begin
		case (cmd.instr.op)
			OP_MUL, OP_MULH: begin
				res      = mpk[W-1:0];
				res_clip = mpk[W];
			end
			OP_ADD, OP_SUB: begin
				res      = sat_res;
				res_clip = ovf;
			end
			OP_DIV: begin
				res      = div_res;
				res_clip = div_clip;
			end
			OP_CPY: begin
				res      = opa;
				res_clip = 1'b0;
			end
			default: begin
				res      = '0;
				res_clip = 1'b0;
			end
		endcase
	end

	// covariance diagonal gets the initial variance, everything else zero
	assign fill_val = ({2'b00, cmd.fill_loc} == L_P00 || {2'b00, cmd.fill_loc} == L_P11 ||
	                   {2'b00, cmd.fill_loc} == L_P22) ? {{(W-VW){1'b0}}, cfg.iv} : '0;

	assign we     = cmd.wb | cmd.fill;
	assign waddr  = cmd.fill ? {cmd.axis, 1'b0, cmd.fill_loc} : {cmd.axis, cmd.instr.dst[4:0]};
	assign wdata  = cmd.fill ? fill_val : res;
	assign wloc   = waddr[4:0];
	assign sh_idx = cmd.axis ? (3'(wloc) + 3'd3) : 3'(wloc);

	kfca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.neg    (opa[W-1]),
		.num    (mag_a),
		.den    (opb),
		.done   (div_done),
		.res    (div_res),
		.clip   (div_clip)
	);

	always_ff @(posedge clk) begin
		rda_q <= rf[addr_a];
		rdb_q <= rf[addr_b];
		if (we) begin
			rf[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			zx_q <= in_data[W-1:0];
			zy_q <= in_data[2*W-1:W];
		end
		if (cmd.mul_en) begin
			prod_q <= mag_a * mag_b;
			pneg_q <= opa[W-1] ^ opb[W-1];
		end
		if (we && wloc < 5'd3) begin
			est_sh_q[sh_idx] <= wdata;
		end
		if (we && wloc == L_P00[4:0]) begin
			var_sh_q[cmd.axis] <= wdata;
		end
		if (cmd.out_load) begin
			out_q <= {1'b0, clip_q | negx | negy, vy, vx,
			          est_sh_q[5], est_sh_q[4], est_sh_q[3],
			          est_sh_q[2], est_sh_q[1], est_sh_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= 1'b0;
			nonpos_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				clip_q <= 1'b0;
			end else if (cmd.wb && res_clip) begin
				clip_q <= 1'b1;
			end
			if (cmd.wb) begin
				nonpos_q <= res[W-1] | (res == '0);
			end
		end
	end

	// a negative position variance reads as zero and counts as a clip
	assign negx = var_sh_q[0][W-1];
	assign negy = var_sh_q[1][W-1];
	assign vx   = negx ? '0 : var_sh_q[0][VW-1:0];
	assign vy   = negy ? '0 : var_sh_q[1][VW-1:0];

	assign sts.div_done = div_done;
	assign sts.nonpos   = nonpos_q;
	assign out_data     = out_q;

endmodule

// ===== rtl/kfca_ctrl.sv =====
module kfca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  logic           cov_reload,
	input  kfca_pkg::sts_t sts,
	output kfca_pkg::cmd_t cmd
);
	import kfca_pkg::*;

	state_t          state_q;
	state_t          state_d;
	logic [PC_W-1:0] pc_q;
	logic            axis_q;
	logic [3:0]      loc_q;
	logic            ovalid_q;
	instr_t          instr;
	logic            axis_end;
	logic            out_free;

	assign instr    = PROG[pc_q];
	assign axis_end = (instr.op == OP_END) || (instr.op == OP_BRP && sts.nonpos);
	assign out_free = !ovalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_LOAD: begin
				if (!cov_reload && axis_q && loc_q == LOC_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cov_reload) begin
					state_d = ST_LOAD;
				end else if (s_tvalid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (axis_end) begin
					state_d = axis_q ? ST_FIN : ST_READ;
				end else if (instr.op != OP_BRP) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: state_d = (instr.op == OP_DIV) ? ST_DIV : ST_WB;
			ST_DIV:  state_d = sts.div_done ? ST_WB : ST_DIV;
			ST_WB:   state_d = ST_READ;
			ST_FIN:  state_d = out_free ? ST_IDLE : ST_FIN;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.instr     = instr;
		cmd.fill_loc  = loc_q;
		cmd.capture   = (state_q == ST_IDLE) && s_tvalid && !cov_reload;
		cmd.mul_en    = (state_q == ST_EXEC) && (instr.op == OP_MUL || instr.op == OP_MULH);
		cmd.div_start = (state_q == ST_EXEC) && (instr.op == OP_DIV);
		cmd.wb        = (state_q == ST_WB);
		cmd.fill      = (state_q == ST_INIT) || (state_q == ST_LOAD);
		cmd.out_load  = (state_q == ST_FIN) && out_free;
		s_tready      = (state_q == ST_IDLE) && !cov_reload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			pc_q     <= '0;
			axis_q   <= 1'b0;
			loc_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= cmd.out_load | (ovalid_q & !m_tready);
			case (state_q)
				ST_INIT, ST_LOAD: begin
					if (cov_reload) begin
						loc_q  <= (state_q == ST_INIT) ? 4'd0 : LOC_FIRST_COV;
						axis_q <= 1'b0;
					end else if (loc_q == LOC_LAST) begin
						loc_q  <= (state_q == ST_INIT) ? 4'd0 : LOC_FIRST_COV;
						axis_q <= 1'b1;
					end else begin
						loc_q <= loc_q + 4'd1;
					end
				end
				ST_IDLE: begin
					pc_q   <= '0;
					axis_q <= 1'b0;
					loc_q  <= LOC_FIRST_COV;
				end
				ST_READ: begin
					if (axis_end) begin
						pc_q   <= '0;
						axis_q <= 1'b1;
					end else if (instr.op == OP_BRP) begin
						pc_q <= pc_q + PC_W'(1);
					end
				end
				ST_WB: pc_q <= pc_q + PC_W'(1);
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_READ && pc_q == '0 && !axis_q))
		else $error("accepted request did not start at the top of the x program");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wb, cmd.fill, cmd.out_load, cmd.capture}))
		else $error("conflicting datapath commands");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_DIV))
		else $error("divide wait entered without a divide start");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

// ===== rtl/kalman_filter_const_accel_2d.sv =====
// an accepted request runs the per-axis microprogram for x, then for y, before its result is loaded
// (per axis: 75 microcode ops, 3 gain divides, branch and end steps)
// a non-positive innovation variance skips that axis's update
// a new request is taken only after the previous result is loaded; the microcode is serial
// reset: a clearing pass over estimate and covariance before the first request,
// and a covariance reload after each initial_variance write made outside a request
module kalman_filter_const_accel_2d (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side: meas_x [31:0], meas_y [63:32]
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [2*kfca_pkg::W-1:0]     s_tdata,
	// master side: est_pos_x, est_vel_x, est_acc_x, est_pos_y, est_vel_y, est_acc_y
	// (32 bits each from bit 0), pos_var_x [222:192], pos_var_y [253:223],
	// saturated [254], zero [255]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [kfca_pkg::OUT_W-1:0]   m_tdata,
	// register write port
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [kfca_pkg::VW-1:0]      cfg_wr_data
);
	import kfca_pkg::*;

	// configuration registers
	logic [DTW-1:0] dt_q;
	logic [VW-1:0]  q_q;
	logic [VW-1:0]  r_q;
	logic [VW-1:0]  iv_q;
	cfg_t           cfg;
	cmd_t           cmd;
	sts_t           sts;
	logic           cov_reload;

	// a new initial variance reloads both covariances unless a request is being processed
	assign cov_reload = cfg_wr_en && (cfg_index == REG_INIT_VAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= RST_SAMPLE_PERIOD;
			q_q  <= RST_PROCESS_NOISE;
			r_q  <= RST_MEAS_NOISE;
			iv_q <= RST_INIT_VAR;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_PERIOD: dt_q <= cfg_wr_data[DTW-1:0];
				REG_PROCESS_NOISE: q_q  <= cfg_wr_data;
				REG_MEAS_NOISE:    r_q  <= cfg_wr_data;
				REG_INIT_VAR:      iv_q <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.dt = dt_q;
	assign cfg.q  = q_q;
	assign cfg.r  = r_q;
	assign cfg.iv = iv_q;

	// sequencer: walks the per-axis microprogram, x then y
	kfca_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.cov_reload (cov_reload),
		.sts        (sts),
		.cmd        (cmd)
	);

	// register file, multiplier, saturating adder, divider and result register
	kfca_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (s_tdata),
		.sts      (sts),
		.out_data (m_tdata)
	);

endmodule

// ===== verif/kalman_filter_const_accel_2d_tb.sv =====
`timescale 1ns / 1ps

module kalman_filter_const_accel_2d_tb;
	import kfca_pkg::*;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [2*W-1:0]       s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_wr_en = 1'b0;
	logic [1:0]           cfg_index = REG_SAMPLE_PERIOD;
	logic [VW-1:0]        cfg_wr_data = '0;

	kalman_filter_const_accel_2d dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the filter: settings, estimate and covariance per axis
	longint    dt_set;
	longint    qn_set;
	longint    rn_set;
	longint    iv_set;
	longint    state_est[6];
	longint    state_cov[18];
	bit        clipped;

	logic [2*W-1:0]   pending_meas[$];
	logic [OUT_W-1:0] expected_est[$];
	bit               no_idle = 1'b0;
	int               gap_left = 0;
	int               stall_left = 0;
	int               mismatches = 0;

	function automatic void add_meas(logic [2*W-1:0] m);
		pending_meas.insert(pending_meas.size(), m);
	endfunction

	function automatic longint sat_word(longint v);
		if (v > WMAX) begin
			clipped = 1'b1;
			return WMAX;
		end
		if (v < WMIN) begin
			clipped = 1'b1;
			return WMIN;
		end
		return v;
	endfunction

	// sign and magnitude to a saturated word
	function automatic longint sat_mag(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (m > lim) begin
			clipped = 1'b1;
			m = lim;
		end
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic logic [127:0] magnitude(longint v);
		return 128'(v < 0 ? -v : v);
	endfunction

	// fixed-point product, rounded half away from zero
	function automatic longint fx_mul(longint a, longint b, int sh);
		logic [127:0] p;
		p = magnitude(a) * magnitude(b);
		p = (p + (128'd1 << (sh - 1))) >> sh;
		return sat_mag((a < 0) != (b < 0), p);
	endfunction

	// a * 2^F / b with b > 0, rounded half away from zero
	function automatic longint fx_div(longint a, longint b);
		logic [127:0] num;
		logic [127:0] quo;
		logic [127:0] rem;
		num = magnitude(a) << F;
		quo = num / 128'(b);
		rem = num % 128'(b);
		if (rem >= 128'(b) - rem) quo = quo + 1;
		return sat_mag(a < 0, quo);
	endfunction

	// x' = A x for one column or row
	function automatic void advance(longint dt, longint h, input longint v[3],
		output longint o[3]);
		o[0] = sat_word(sat_word(v[0] + fx_mul(dt, v[1], F)) + fx_mul(h, v[2], F));
		o[1] = sat_word(v[1] + fx_mul(dt, v[2], F));
		o[2] = v[2];
	endfunction

	function automatic void reload_cov();
		for (int i = 0; i < 18; i++) state_cov[i] = 0;
		for (int i = 0; i < 3; i++) begin
			state_cov[i * 4] = iv_set;
			state_cov[9 + i * 4] = iv_set;
		end
	endfunction

	function automatic void axis_track(int ax, longint z);
		longint h;
		longint v[3];
		longint o[3];
		longint m[9];
		longint k[3];
		longint row0[3];
		longint s;
		longint e;
		h = fx_mul(dt_set, dt_set, F + 1);
		for (int i = 0; i < 3; i++) v[i] = state_est[ax * 3 + i];
		advance(dt_set, h, v, o);
		for (int i = 0; i < 3; i++) state_est[ax * 3 + i] = o[i];
		// covariance predict: columns of A P first, then rows times A^T
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++) v[i] = state_cov[ax * 9 + i * 3 + j];
			advance(dt_set, h, v, o);
			for (int i = 0; i < 3; i++) m[i * 3 + j] = o[i];
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) v[j] = m[i * 3 + j];
			advance(dt_set, h, v, o);
			for (int j = 0; j < 3; j++) state_cov[ax * 9 + i * 3 + j] = o[j];
			state_cov[ax * 9 + i * 4] = sat_word(state_cov[ax * 9 + i * 4] + qn_set);
		end
		// update skipped when the innovation variance is not positive
		s = sat_word(state_cov[ax * 9] + rn_set);
		if (s <= 0) return;
		e = sat_word(z - state_est[ax * 3]);
		for (int i = 0; i < 3; i++) begin
			k[i] = fx_div(state_cov[ax * 9 + i * 3], s);
			row0[i] = state_cov[ax * 9 + i];
		end
		for (int i = 0; i < 3; i++) begin
			state_est[ax * 3 + i] = sat_word(state_est[ax * 3 + i] + fx_mul(k[i], e, F));
			for (int j = 0; j < 3; j++)
				state_cov[ax * 9 + i * 3 + j] =
					sat_word(state_cov[ax * 9 + i * 3 + j] - fx_mul(k[i], row0[j], F));
		end
	endfunction

	function automatic logic [VW-1:0] var_out(longint v);
		if (v < 0) begin
			clipped = 1'b1;
			return '0;
		end
		return VW'(v);
	endfunction

	// one measurement pair in, one packed estimate out
	function automatic logic [OUT_W-1:0] filter_step(logic [2*W-1:0] meas);
		logic [OUT_W-1:0] r;
		logic [VW-1:0]    vx;
		logic [VW-1:0]    vy;
		clipped = 1'b0;
		axis_track(0, longint'($signed(meas[W-1:0])));
		axis_track(1, longint'($signed(meas[2*W-1:W])));
		r = '0;
		for (int i = 0; i < 6; i++) r[W*i +: W] = state_est[i][W-1:0];
		vx = var_out(state_cov[0]);
		vy = var_out(state_cov[9]);
		r[6*W +: VW] = vx;
		r[6*W+VW +: VW] = vy;
		r[6*W+2*VW] = clipped;
		return r;
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	// request driver: takes from the pending queue and predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_est.insert(expected_est.size(), filter_step(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_meas.size() > 0) begin
					s_tdata <= pending_meas.pop_front();
					s_tvalid <= 1'b1;
					gap_left <= draw_wait();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		logic [OUT_W-1:0] want;
		int               st;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			if (expected_est.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				want = expected_est.pop_front();
				if (want !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10) begin
						for (int i = 0; i < 6; i++)
							if (want[W*i +: W] !== m_tdata[W*i +: W])
								$display("estimate word %0d: expected %h got %h",
									i, want[W*i +: W], m_tdata[W*i +: W]);
						if (want[6*W +: 2*VW] !== m_tdata[6*W +: 2*VW])
							$display("pos_var x/y: expected %h %h got %h %h",
								want[6*W +: VW], want[6*W+VW +: VW],
								m_tdata[6*W +: VW], m_tdata[6*W+VW +: VW]);
						if (want[OUT_W-1 -: 2] !== m_tdata[OUT_W-1 -: 2])
							$display("saturated/pad: expected %b got %b",
								want[OUT_W-1 -: 2], m_tdata[OUT_W-1 -: 2]);
					end
				end
			end
			st = draw_wait();
			stall_left <= st;
			m_tready <= (st == 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// register write while idle, mirrored into the predictor
	task automatic write_reg(logic [1:0] idx, logic [VW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SAMPLE_PERIOD: dt_set = longint'(val[DTW-1:0]);
			REG_PROCESS_NOISE: qn_set = longint'(val);
			REG_MEAS_NOISE:    rn_set = longint'(val);
			REG_INIT_VAR: begin
				iv_set = longint'(val);
				reload_cov();
			end
			default: begin
			end
		endcase
		// covariance reload pass
		repeat (30) @(posedge clk);
	endtask

	task automatic drain();
		while (pending_meas.size() > 0 || s_tvalid || expected_est.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [2*W-1:0] pair(int x, int y);
		return {y, x};
	endfunction

	// mostly smooth tracks with noise, some raw random words
	task automatic random_burst(int n);
		int px;
		int py;
		int vx;
		int vy;
		int left;
		left = 0;
		px = 0; py = 0; vx = 0; vy = 0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = $urandom_range(5, 40);
				px = $signed($urandom) >>> $urandom_range(4, 16);
				py = $signed($urandom) >>> $urandom_range(4, 16);
				vx = $signed($urandom) >>> $urandom_range(12, 24);
				vy = $signed($urandom) >>> $urandom_range(12, 24);
			end
			left--;
			if ($urandom_range(0, 9) == 0) begin
				add_meas({$urandom, $urandom});
			end else begin
				px += vx;
				py += vy;
				vx += $signed($urandom_range(0, 2047)) - 1024;
				vy += $signed($urandom_range(0, 2047)) - 1024;
				add_meas(pair(px + $urandom_range(0, 8191) - 4096,
					py + $urandom_range(0, 8191) - 4096));
			end
		end
	endtask

	initial begin
		dt_set = 64'(RST_SAMPLE_PERIOD);
		qn_set = 64'(RST_PROCESS_NOISE);
		rn_set = 64'(RST_MEAS_NOISE);
		iv_set = 64'(RST_INIT_VAR);
		for (int i = 0; i < 6; i++) state_est[i] = 0;
		reload_cov();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// clearing pass after reset
		repeat (40) @(posedge clk);

		// directed: word extremes at the reset settings
		add_meas(pair(0, 0));
		add_meas(pair(32'h7fffffff, 32'h80000000));
		add_meas(pair(32'h80000000, 32'h7fffffff));
		add_meas(pair(32'hffffffff, 32'h00000001));
		add_meas(pair(32'h7fffffff, 32'h7fffffff));
		add_meas(pair(32'h80000000, 32'h80000000));
		add_meas(pair(32'h00010000, 32'hffff0000));
		drain();

		// zero sample period: identity transition, largest noises
		write_reg(REG_SAMPLE_PERIOD, '0);
		write_reg(REG_PROCESS_NOISE, {VW{1'b1}});
		write_reg(REG_MEAS_NOISE, {VW{1'b1}});
		write_reg(REG_INIT_VAR, {VW{1'b1}});
		add_meas(pair(32'h7fffffff, 32'h80000000));
		add_meas(pair(32'h12345678, 32'hedcba987));
		add_meas(pair(0, 0));
		drain();

		// largest sample period used here, no process noise, smallest nonzero measurement noise
		write_reg(REG_SAMPLE_PERIOD, VW'(655360));
		write_reg(REG_PROCESS_NOISE, '0);
		write_reg(REG_MEAS_NOISE, VW'(1));
		write_reg(REG_INIT_VAR, '0);
		add_meas(pair(32'h00100000, 32'hfff00000));
		add_meas(pair(32'h7fffffff, 32'h80000000));
		add_meas(pair(32'h80000000, 32'h7fffffff));
		add_meas(pair(0, 0));
		drain();

		// random phases over several settings, including back-to-back stretches
		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph % 3 == 1);
			case (ph)
				0: begin
					write_reg(REG_SAMPLE_PERIOD, VW'(6554));
					write_reg(REG_PROCESS_NOISE, VW'(65536));
					write_reg(REG_MEAS_NOISE, VW'(655));
					write_reg(REG_INIT_VAR, VW'(6553600));
				end
				1: begin
					write_reg(REG_SAMPLE_PERIOD, VW'(655360));
					write_reg(REG_PROCESS_NOISE, {VW{1'b1}});
				end
				2: begin
					write_reg(REG_SAMPLE_PERIOD, VW'(1));
					write_reg(REG_MEAS_NOISE, {VW{1'b1}});
					write_reg(REG_INIT_VAR, '0);
				end
				default: begin
					write_reg(REG_SAMPLE_PERIOD, VW'($urandom_range(1, 655360)));
					write_reg(REG_PROCESS_NOISE, VW'($urandom >> $urandom_range(1, 31)));
					write_reg(REG_MEAS_NOISE, VW'(($urandom >> $urandom_range(1, 31)) | 1));
					write_reg(REG_INIT_VAR, VW'($urandom >> $urandom_range(1, 31)));
				end
			endcase
			random_burst(125);
			drain();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// hard limit on the whole run
	initial begin
		#40ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kfca_pkg.sv
rtl/kfca_div.sv
rtl/kfca_dp.sv
rtl/kfca_ctrl.sv
rtl/kalman_filter_const_accel_2d.sv
verif/kalman_filter_const_accel_2d_tb.sv
